FILE: hw/rtl/htb_pkg.sv
// Shared widths and codes for the Huffman code table builder.
`timescale 1ns / 1ps
package htb_pkg;

  localparam int ActionW  = 2;
  localparam int SymbolW  = 8;
  localparam int FreqW    = 16;
  localparam int StatusW  = 2;
  localparam int LenW     = 6;
  localparam int CodeW    = 32;
  localparam int TableSize = 256;

  localparam logic [ActionW-1:0] ACT_ADD    = 2'd0;
  localparam logic [ActionW-1:0] ACT_BUILD  = 2'd1;
  localparam logic [ActionW-1:0] ACT_LOOKUP = 2'd2;

  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL     = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY    = 2'd2;
  localparam logic [StatusW-1:0] ST_TOO_LONG = 2'd3;

endpackage

FILE: hw/rtl/htb_if.sv
// Request and result channel interfaces of the Huffman code table builder.
`timescale 1ns / 1ps
interface htb_req_if import htb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [SymbolW-1:0] symbol;
  logic [FreqW-1:0]   frequency;

  modport source (output valid, action, symbol, frequency, input ready);
  modport sink (input valid, action, symbol, frequency, output ready);
endinterface

interface htb_res_if import htb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [LenW-1:0]    code_length;
  logic [CodeW-1:0]   code_value;

  modport source (output valid, status, code_length, code_value, input ready);
  modport sink (input valid, status, code_length, code_value, output ready);
endinterface

FILE: hw/rtl/huffman_code_table_builder.sv
// Huffman code table builder: leaf store, min-heap tree construction and code walk.
`timescale 1ns / 1ps
// Takes one request at a time and answers each with one result. An add request
// goes straight to the result stage and a lookup first reads the code table; both
// then wait for the result slot. A build request runs a sequencer around one heap
// memory port: it loads the heap one leaf at a time, then runs a bottom-up
// heapify. Each merge takes the two smallest nodes off the heap, each with a
// sift-down, and pushes their sum back with a sift-up. A tree walk of the
// finished tree follows. The code table is cleared at once when a build
// starts. Leaves persist across builds.
module huffman_code_table_builder import htb_pkg::*; #(
  parameter int MAX_SYMBOLS  = 256,
  parameter int MAX_CODE_LEN = 32,
  parameter int FREQ_BITS    = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  htb_req_if.sink    item_i,
  htb_res_if.source  result_o
);

  localparam int NodeCap   = 2 * MAX_SYMBOLS - 1;
  localparam int NB        = $clog2(NodeCap);
  localparam int LB        = $clog2(MAX_SYMBOLS + 1);
  localparam int HB        = $clog2(MAX_SYMBOLS);
  localparam int WW        = FREQ_BITS + 8;
  localparam int CodeLimit = (MAX_CODE_LEN < CodeW) ? MAX_CODE_LEN : CodeW;
  localparam int WalkCap   = CodeLimit + 2;
  localparam int SB        = $clog2(WalkCap + 1);
  localparam int SPI       = $clog2(WalkCap);
  localparam int TB        = $clog2(TableSize);
  localparam logic [WW-1:0] FreqMask = WW'({FREQ_BITS{1'b1}});

  typedef struct packed {
    logic [NB-1:0] node;
    logic [WW-1:0] wt;
  } heap_t;

  typedef struct packed {
    logic [NB-1:0]    node;
    logic [LenW-1:0]  depth;
    logic [CodeW-1:0] code;
  } stk_t;

  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [CodeW-1:0] code;
  } tab_t;

  typedef enum logic [23:0] {
    S_IDLE    = 24'h000001,
    S_LOOK    = 24'h000002,
    S_RESP    = 24'h000004,
    S_FILL_A  = 24'h000008,
    S_FILL_W  = 24'h000010,
    S_HP_RD   = 24'h000020,
    S_HP_LD   = 24'h000040,
    S_SD_L    = 24'h000080,
    S_SD_LC   = 24'h000100,
    S_SD_RC   = 24'h000200,
    S_SD_DEC  = 24'h000400,
    S_MG      = 24'h000800,
    S_TK_RD   = 24'h001000,
    S_TK_TOP  = 24'h002000,
    S_TK_LAST = 24'h004000,
    S_NEW     = 24'h008000,
    S_PU_CHK  = 24'h010000,
    S_PU_CMP  = 24'h020000,
    S_RT_RD   = 24'h040000,
    S_RT      = 24'h080000,
    S_WK      = 24'h100000,
    S_WK_E    = 24'h200000,
    S_WK_N    = 24'h400000,
    S_WK_P    = 24'h800000
  } state_e;

  typedef enum logic [1:0] {
    RET_HEAPIFY,
    RET_TAKE1,
    RET_TAKE2
  } ret_e;

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;

  logic [LB-1:0]      leaf_cnt_q, leaf_cnt_d;
  logic [LB-1:0]      heap_cnt_q, heap_cnt_d;
  logic [NB-1:0]      next_q, next_d;
  logic [LB-1:0]      pos_q, pos_d;
  logic [LB-1:0]      best_q, best_d;
  logic [LB-1:0]      i_q, i_d;
  heap_t              x_q, x_d;
  heap_t              be_q, be_d;
  heap_t              a_q, a_d;
  heap_t              b_q, b_d;
  logic [SB-1:0]      sp_q, sp_d;
  stk_t               e_q, e_d;
  logic [NB-1:0]      lc_q, lc_d;
  logic               too_long_q, too_long_d;
  logic [StatusW-1:0] st_q, st_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [CodeW-1:0]   code_q, code_d;
  logic               tv_q, tv_d;
  logic [TableSize-1:0] tvalid_q, tvalid_d;
  logic               ovalid_q, ovalid_d;
  logic [StatusW-1:0] ostatus_q, ostatus_d;
  logic [LenW-1:0]    olen_q, olen_d;
  logic [CodeW-1:0]   ocode_q, ocode_d;

  // Memories and their ports.
  logic [WW-1:0]      wt_mem [MAX_SYMBOLS];
  logic [SymbolW-1:0] sym_mem [MAX_SYMBOLS];
  logic [2*NB-1:0]    ch_mem [NodeCap];
  heap_t              heap_mem [MAX_SYMBOLS];
  stk_t               stk_mem [WalkCap];
  tab_t               tab_mem [TableSize];

  logic               leaf_we;
  logic [HB-1:0]      leaf_wa;
  logic [WW-1:0]      wt_wd;
  logic [SymbolW-1:0] sym_wd;
  logic [HB-1:0]      wt_ra, sym_ra;
  logic [WW-1:0]      wt_rd_q;
  logic [SymbolW-1:0] sym_rd_q;
  logic               ch_we;
  logic [NB-1:0]      ch_wa, ch_ra;
  logic [2*NB-1:0]    ch_wd, ch_rd_q;
  logic               heap_we;
  logic [HB-1:0]      heap_wa, heap_ra;
  heap_t              heap_wd, heap_rd_q;
  logic               stk_we;
  logic [SPI-1:0]     stk_wa, stk_ra;
  stk_t               stk_wd, stk_rd_q;
  logic               tab_we;
  logic [TB-1:0]      tab_wa, tab_ra;
  tab_t               tab_wd, tab_rd_q;

  // Heap index arithmetic, one bit wider so child positions cannot wrap.
  logic [LB:0]   lc_pos, rc_pos;
  logic [LB-1:0] parent_pos;
  logic [LB-1:0] heap_start;

  assign lc_pos     = {pos_q, 1'b1};
  assign rc_pos     = {pos_q, 1'b0} + (LB + 1)'(2);
  assign parent_pos = (pos_q - LB'(1)) >> 1;
  assign heap_start = (leaf_cnt_q >= LB'(2)) ? ((leaf_cnt_q - LB'(2)) >> 1) : '0;

  assign item_i.ready       = (state_q == S_IDLE);
  assign result_o.valid     = ovalid_q;
  assign result_o.status    = ostatus_q;
  assign result_o.code_length = olen_q;
  assign result_o.code_value  = ocode_q;

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    leaf_cnt_d = leaf_cnt_q;
    heap_cnt_d = heap_cnt_q;
    next_d     = next_q;
    pos_d      = pos_q;
    best_d     = best_q;
    i_d        = i_q;
    x_d        = x_q;
    be_d       = be_q;
    a_d        = a_q;
    b_d        = b_q;
    sp_d       = sp_q;
    e_d        = e_q;
    lc_d       = lc_q;
    too_long_d = too_long_q;
    st_d       = st_q;
    len_d      = len_q;
    code_d     = code_q;
    tv_d       = tv_q;
    tvalid_d   = tvalid_q;
    ovalid_d   = ovalid_q & ~result_o.ready;
    ostatus_d  = ostatus_q;
    olen_d     = olen_q;
    ocode_d    = ocode_q;

    leaf_we = 1'b0;
    leaf_wa = leaf_cnt_q[HB-1:0];
    wt_wd   = WW'(item_i.frequency) & FreqMask;
    sym_wd  = item_i.symbol;
    wt_ra   = i_q[HB-1:0];
    sym_ra  = stk_rd_q.node[HB-1:0];
    ch_we   = 1'b0;
    ch_wa   = next_q;
    ch_wd   = {a_q.node, b_q.node};
    ch_ra   = stk_rd_q.node;
    heap_we = 1'b0;
    heap_wa = pos_q[HB-1:0];
    heap_wd = x_q;
    heap_ra = '0;
    stk_we  = 1'b0;
    stk_wa  = sp_q[SPI-1:0];
    stk_wd  = e_q;
    stk_ra  = '0;
    tab_we  = 1'b0;
    tab_wa  = sym_rd_q;
    tab_wd  = '{len: e_q.depth, code: e_q.code};
    tab_ra  = item_i.symbol;

    unique case (state_q)
      S_IDLE: begin
        tv_d = tvalid_q[item_i.symbol];
        if (item_i.valid) begin
          st_d   = ST_OK;
          len_d  = '0;
          code_d = '0;
          state_d = S_RESP;
          case (item_i.action)
            ACT_ADD: begin
              if (leaf_cnt_q == LB'(MAX_SYMBOLS)) begin
                st_d = ST_FULL;
              end else begin
                leaf_we    = 1'b1;
                leaf_cnt_d = leaf_cnt_q + LB'(1);
              end
            end
            ACT_BUILD: begin
              tvalid_d   = '0;
              too_long_d = 1'b0;
              next_d     = NB'(leaf_cnt_q);
              i_d        = '0;
              if (leaf_cnt_q == '0) begin
                st_d = ST_EMPTY;
              end else begin
                state_d = S_FILL_A;
              end
            end
            ACT_LOOKUP: state_d = S_LOOK;
            default: ;
          endcase
        end
      end
      S_LOOK: begin
        len_d   = tv_q ? tab_rd_q.len : '0;
        code_d  = tv_q ? tab_rd_q.code : '0;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!ovalid_q || result_o.ready) begin
          ovalid_d  = 1'b1;
          ostatus_d = st_q;
          olen_d    = len_q;
          ocode_d   = code_q;
          state_d   = S_IDLE;
        end
      end
      S_FILL_A: state_d = S_FILL_W;
      S_FILL_W: begin
        heap_we = 1'b1;
        heap_wa = i_q[HB-1:0];
        heap_wd = '{node: NB'(i_q), wt: wt_rd_q};
        if (i_q == leaf_cnt_q - LB'(1)) begin
          heap_cnt_d = leaf_cnt_q;
          i_d        = heap_start;
          state_d    = S_HP_RD;
        end else begin
          i_d     = i_q + LB'(1);
          state_d = S_FILL_A;
        end
      end
      S_HP_RD: begin
        heap_ra = i_q[HB-1:0];
        state_d = S_HP_LD;
      end
      S_HP_LD: begin
        x_d     = heap_rd_q;
        pos_d   = i_q;
        ret_d   = RET_HEAPIFY;
        state_d = S_SD_L;
      end
      S_SD_L: begin
        best_d = pos_q;
        be_d   = x_q;
        if (lc_pos < {1'b0, heap_cnt_q}) begin
          heap_ra = lc_pos[HB-1:0];
          state_d = S_SD_LC;
        end else begin
          state_d = S_SD_DEC;
        end
      end
      S_SD_LC: begin
        if (heap_rd_q.wt < x_q.wt) begin
          best_d = lc_pos[LB-1:0];
          be_d   = heap_rd_q;
        end
        if (rc_pos < {1'b0, heap_cnt_q}) begin
          heap_ra = rc_pos[HB-1:0];
          state_d = S_SD_RC;
        end else begin
          state_d = S_SD_DEC;
        end
      end
      S_SD_RC: begin
        if (heap_rd_q.wt < be_q.wt) begin
          best_d = rc_pos[LB-1:0];
          be_d   = heap_rd_q;
        end
        state_d = S_SD_DEC;
      end
      S_SD_DEC: begin
        heap_we = 1'b1;
        if (best_q != pos_q) begin
          // The smaller child moves up and the held entry keeps sinking.
          heap_wd = be_q;
          pos_d   = best_q;
          state_d = S_SD_L;
        end else begin
          case (ret_q)
            RET_HEAPIFY: begin
              if (i_q == '0) begin
                state_d = S_MG;
              end else begin
                i_d     = i_q - LB'(1);
                state_d = S_HP_RD;
              end
            end
            RET_TAKE1: begin
              ret_d   = RET_TAKE2;
              state_d = S_TK_RD;
            end
            default: state_d = S_NEW;
          endcase
        end
      end
      S_MG: begin
        if (heap_cnt_q > LB'(1)) begin
          ret_d   = RET_TAKE1;
          state_d = S_TK_RD;
        end else begin
          state_d = S_RT_RD;
        end
      end
      S_TK_RD: begin
        heap_ra = '0;
        state_d = S_TK_TOP;
      end
      S_TK_TOP: begin
        if (ret_q == RET_TAKE1) begin
          a_d = heap_rd_q;
        end else begin
          b_d = heap_rd_q;
        end
        heap_ra = HB'(heap_cnt_q - LB'(1));
        state_d = S_TK_LAST;
      end
      S_TK_LAST: begin
        x_d        = heap_rd_q;
        heap_cnt_d = heap_cnt_q - LB'(1);
        pos_d      = '0;
        state_d    = S_SD_L;
      end
      S_NEW: begin
        ch_we      = 1'b1;
        x_d        = '{node: next_q, wt: a_q.wt + b_q.wt};
        pos_d      = heap_cnt_q;
        heap_cnt_d = heap_cnt_q + LB'(1);
        state_d    = S_PU_CHK;
      end
      S_PU_CHK: begin
        if (pos_q == '0) begin
          heap_we = 1'b1;
          next_d  = next_q + NB'(1);
          state_d = S_MG;
        end else begin
          heap_ra = parent_pos[HB-1:0];
          state_d = S_PU_CMP;
        end
      end
      S_PU_CMP: begin
        heap_we = 1'b1;
        if (x_q.wt < heap_rd_q.wt) begin
          heap_wd = heap_rd_q;
          pos_d   = parent_pos;
          state_d = S_PU_CHK;
        end else begin
          next_d  = next_q + NB'(1);
          state_d = S_MG;
        end
      end
      S_RT_RD: begin
        heap_ra = '0;
        state_d = S_RT;
      end
      S_RT: begin
        stk_we  = 1'b1;
        stk_wa  = '0;
        stk_wd  = '{node: heap_rd_q.node, depth: '0, code: '0};
        sp_d    = SB'(1);
        state_d = S_WK;
      end
      S_WK: begin
        if (sp_q == '0) begin
          st_d    = too_long_q ? ST_TOO_LONG : ST_OK;
          state_d = S_RESP;
        end else begin
          stk_ra  = SPI'(sp_q - SB'(1));
          sp_d    = sp_q - SB'(1);
          state_d = S_WK_E;
        end
      end
      S_WK_E: begin
        e_d     = stk_rd_q;
        state_d = S_WK_N;
      end
      S_WK_N: begin
        state_d = S_WK;
        if (e_q.node < NB'(leaf_cnt_q)) begin
          tab_we           = 1'b1;
          tvalid_d[sym_rd_q] = 1'b1;
        end else if (({1'b0, e_q.depth} >= (LenW + 1)'(CodeLimit)) ||
                     ((SB + 1)'(sp_q) + (SB + 1)'(2) > (SB + 1)'(WalkCap))) begin
          too_long_d = 1'b1;
        end else begin
          // Right child goes on first so the left subtree is walked first.
          stk_we  = 1'b1;
          stk_wd  = '{node: ch_rd_q[NB-1:0], depth: e_q.depth + LenW'(1),
                      code: e_q.code | (CodeW'(1) << e_q.depth)};
          lc_d    = ch_rd_q[2*NB-1:NB];
          sp_d    = sp_q + SB'(1);
          state_d = S_WK_P;
        end
      end
      S_WK_P: begin
        stk_we  = 1'b1;
        stk_wd  = '{node: lc_q, depth: e_q.depth + LenW'(1), code: e_q.code};
        sp_d    = sp_q + SB'(1);
        state_d = S_WK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ovalid_q   <= 1'b0;
      tvalid_q   <= '0;
      leaf_cnt_q <= '0;
      heap_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      ovalid_q   <= ovalid_d;
      tvalid_q   <= tvalid_d;
      leaf_cnt_q <= leaf_cnt_d;
      heap_cnt_q <= heap_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q      <= ret_d;
    next_q     <= next_d;
    pos_q      <= pos_d;
    best_q     <= best_d;
    i_q        <= i_d;
    x_q        <= x_d;
    be_q       <= be_d;
    a_q        <= a_d;
    b_q        <= b_d;
    sp_q       <= sp_d;
    e_q        <= e_d;
    lc_q       <= lc_d;
    too_long_q <= too_long_d;
    st_q       <= st_d;
    len_q      <= len_d;
    code_q     <= code_d;
    tv_q       <= tv_d;
    ostatus_q  <= ostatus_d;
    olen_q     <= olen_d;
    ocode_q    <= ocode_d;
  end

  always_ff @(posedge clk_i) begin
    if (leaf_we) begin
      wt_mem[leaf_wa]  <= wt_wd;
      sym_mem[leaf_wa] <= sym_wd;
    end
    wt_rd_q  <= wt_mem[wt_ra];
    sym_rd_q <= sym_mem[sym_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ch_we) begin
      ch_mem[ch_wa] <= ch_wd;
    end
    ch_rd_q <= ch_mem[ch_ra];
  end

  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    heap_rd_q <= heap_mem[heap_ra];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd_q <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[tab_wa] <= tab_wd;
    end
    tab_rd_q <= tab_mem[tab_ra];
  end

endmodule

FILE: dv/huffman_code_table_builder_test.sv
// Self-checking testbench for the Huffman code table builder.
`timescale 1ns / 1ps
module huffman_code_table_builder_test;
  import htb_pkg::*;

  localparam logic [ActionW-1:0] ACT_UNUSED = 2'd3;
  localparam int LeafCap   = 256;
  localparam int NodeCap   = 2 * LeafCap - 1;
  localparam int CodeLimit = 32;
  localparam int WalkCap   = CodeLimit + 2;
  localparam int RandomItems = 650;
  localparam longint CycleLimit = 20_000_000;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [LenW-1:0]    code_length;
    logic [CodeW-1:0]   code_value;
  } answer_t;

  typedef struct {
    logic [ActionW-1:0] action;
    logic [SymbolW-1:0] symbol;
    logic [FreqW-1:0]   frequency;
    bit                 fixed;
    answer_t            answer;
  } request_row_t;

  logic clk;
  logic rst_n;
  htb_req_if req_if();
  htb_res_if res_if();

  huffman_code_table_builder uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (req_if),
    .result_o(res_if)
  );

  // Shadow of the block's tree builder state.
  logic [23:0]        tree_weight [NodeCap];
  logic [8:0]         tree_left   [NodeCap];
  logic [8:0]         tree_right  [NodeCap];
  logic [SymbolW-1:0] tree_symbol [NodeCap];
  bit                 tree_is_leaf[NodeCap];
  logic [8:0]         heap_node   [LeafCap];
  int                 heap_size;
  int                 leaves_loaded;
  logic [LenW-1:0]    code_len_table [TableSize];
  logic [CodeW-1:0]   code_bits_table[TableSize];

  answer_t pending_answers[$];
  int      errors;
  bit      hold_results;
  longint  cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void heap_sift(int pos);
    int lc, rc, best;
    logic [8:0] t;
    forever begin
      lc = 2 * pos + 1;
      rc = 2 * pos + 2;
      best = pos;
      if (lc < heap_size && tree_weight[heap_node[lc]] < tree_weight[heap_node[best]]) best = lc;
      if (rc < heap_size && tree_weight[heap_node[rc]] < tree_weight[heap_node[best]]) best = rc;
      if (best == pos) return;
      t = heap_node[best];
      heap_node[best] = heap_node[pos];
      heap_node[pos] = t;
      pos = best;
    end
  endfunction

  function automatic logic [8:0] heap_pop();
    logic [8:0] top;
    top = heap_node[0];
    heap_node[0] = heap_node[heap_size - 1];
    heap_size--;
    heap_sift(0);
    return top;
  endfunction

  function automatic void heap_push(logic [8:0] n);
    int pos;
    heap_size++;
    pos = heap_size - 1;
    while (pos != 0 && tree_weight[n] < tree_weight[heap_node[(pos - 1) / 2]]) begin
      heap_node[pos] = heap_node[(pos - 1) / 2];
      pos = (pos - 1) / 2;
    end
    heap_node[pos] = n;
  endfunction

  function automatic logic [StatusW-1:0] build_code_table();
    int start, next_node, sp;
    logic [8:0] a, b;
    logic [8:0]       walk_node [WalkCap];
    int               walk_depth[WalkCap];
    logic [CodeW-1:0] walk_code [WalkCap];
    logic [8:0]       n;
    int               d;
    logic [CodeW-1:0] c;
    bit too_long;
    too_long = 1'b0;
    for (int i = 0; i < TableSize; i++) begin
      code_len_table[i] = '0;
      code_bits_table[i] = '0;
    end
    if (leaves_loaded == 0) return ST_EMPTY;
    for (int i = 0; i < leaves_loaded; i++) heap_node[i] = 9'(i);
    heap_size = leaves_loaded;
    start = (leaves_loaded >= 2) ? (leaves_loaded - 2) / 2 : 0;
    for (int i = start; i >= 0; i--) heap_sift(i);
    next_node = leaves_loaded;
    while (heap_size > 1 && next_node < NodeCap) begin
      a = heap_pop();
      b = heap_pop();
      tree_weight[next_node] = tree_weight[a] + tree_weight[b];
      tree_left[next_node] = a;
      tree_right[next_node] = b;
      tree_is_leaf[next_node] = 1'b0;
      tree_symbol[next_node] = '0;
      heap_push(9'(next_node));
      next_node++;
    end
    walk_node[0] = heap_pop();
    walk_depth[0] = 0;
    walk_code[0] = '0;
    sp = 1;
    while (sp > 0) begin
      sp--;
      n = walk_node[sp];
      d = walk_depth[sp];
      c = walk_code[sp];
      if (tree_is_leaf[n]) begin
        code_len_table[tree_symbol[n]] = LenW'(d);
        code_bits_table[tree_symbol[n]] = c;
      end else if (d >= CodeLimit || sp + 2 > WalkCap) begin
        too_long = 1'b1;
      end else begin
        walk_node[sp] = tree_right[n];
        walk_depth[sp] = d + 1;
        walk_code[sp] = c | (32'(1) << d);
        sp++;
        walk_node[sp] = tree_left[n];
        walk_depth[sp] = d + 1;
        walk_code[sp] = c;
        sp++;
      end
    end
    return too_long ? ST_TOO_LONG : ST_OK;
  endfunction

  function automatic answer_t predict_answer(logic [ActionW-1:0] action,
                                             logic [SymbolW-1:0] symbol,
                                             logic [FreqW-1:0] frequency);
    answer_t ans;
    ans = '0;
    ans.status = ST_OK;
    case (action)
      ACT_ADD: begin
        if (leaves_loaded >= LeafCap) begin
          ans.status = ST_FULL;
        end else begin
          tree_weight[leaves_loaded] = 24'(frequency);
          tree_symbol[leaves_loaded] = symbol;
          tree_is_leaf[leaves_loaded] = 1'b1;
          tree_left[leaves_loaded] = '0;
          tree_right[leaves_loaded] = '0;
          leaves_loaded++;
        end
      end
      ACT_BUILD: ans.status = build_code_table();
      ACT_LOOKUP: begin
        ans.code_length = code_len_table[symbol];
        ans.code_value = code_bits_table[symbol];
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic send_request(request_row_t row);
    answer_t predicted;
    int gap;
    gap = $urandom_range(0, 9);
    if (($urandom_range(0, 99) < 30)) gap = 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.action <= row.action;
    req_if.symbol <= row.symbol;
    req_if.frequency <= row.frequency;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
    predicted = predict_answer(row.action, row.symbol, row.frequency);
    pending_answers.push_back(row.fixed ? row.answer : predicted);
  endtask

  function automatic request_row_t make_row(logic [ActionW-1:0] action,
                                            logic [SymbolW-1:0] symbol,
                                            logic [FreqW-1:0] frequency);
    request_row_t r;
    r.action = action;
    r.symbol = symbol;
    r.frequency = frequency;
    r.fixed = 1'b0;
    r.answer = '0;
    return r;
  endfunction

  function automatic logic [FreqW-1:0] random_frequency();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return FreqW'($urandom_range(0, 3));
      2: return '1;
      default: return FreqW'($urandom);
    endcase
  endfunction

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin
    int stall;
    res_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(0, 9);
      if (hold_results) begin
        hold_results = 1'b0;
        stall = 400;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!(res_if.valid && res_if.ready));
    end
  end

  always @(posedge clk) begin
    answer_t exp_ans;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_answers.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        exp_ans = pending_answers.pop_front();
        if (res_if.status !== exp_ans.status) begin
          $error("status: expected %0d, got %0d", exp_ans.status, res_if.status);
          errors++;
        end
        if (res_if.code_length !== exp_ans.code_length) begin
          $error("code_length: expected %0d, got %0d", exp_ans.code_length,
                 res_if.code_length);
          errors++;
        end
        if (res_if.code_value !== exp_ans.code_value) begin
          $error("code_value: expected %h, got %h", exp_ans.code_value, res_if.code_value);
          errors++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    request_row_t directed[$];
    request_row_t r;
    logic [SymbolW-1:0] used_symbols[$];
    int sent, adds, lookups, drain;
    bit held;

    errors = 0;
    hold_results = 1'b0;
    held = 1'b0;
    leaves_loaded = 0;
    heap_size = 0;
    for (int i = 0; i < TableSize; i++) begin
      code_len_table[i] = '0;
      code_bits_table[i] = '0;
    end
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.action = ACT_ADD;
    req_if.symbol = '0;
    req_if.frequency = '0;

    // Rows with a fixed answer: after reset, empty build, unused code, lone symbol.
    r = make_row(ACT_LOOKUP, 8'h00, '0);   r.fixed = 1'b1; directed.push_back(r);
    r = make_row(ACT_LOOKUP, 8'hff, '1);   r.fixed = 1'b1; directed.push_back(r);
    r = make_row(ACT_BUILD, 8'h00, '0);    r.fixed = 1'b1;
    r.answer.status = ST_EMPTY;            directed.push_back(r);
    r = make_row(ACT_UNUSED, 8'hff, '1);   r.fixed = 1'b1; directed.push_back(r);
    r = make_row(ACT_ADD, 8'h41, '0);      r.fixed = 1'b1; directed.push_back(r);
    r = make_row(ACT_BUILD, 8'h00, '0);    r.fixed = 1'b1; directed.push_back(r);
    r = make_row(ACT_LOOKUP, 8'h41, '0);   r.fixed = 1'b1; directed.push_back(r);
    // A repeated symbol and extreme weights go to the predictor.
    directed.push_back(make_row(ACT_ADD, 8'hff, '1));
    directed.push_back(make_row(ACT_ADD, 8'h00, '1));
    directed.push_back(make_row(ACT_ADD, 8'h41, 16'd1));
    directed.push_back(make_row(ACT_ADD, 8'h80, '0));
    directed.push_back(make_row(ACT_BUILD, 8'h00, '0));
    directed.push_back(make_row(ACT_LOOKUP, 8'h41, '0));
    directed.push_back(make_row(ACT_LOOKUP, 8'hff, '0));
    directed.push_back(make_row(ACT_LOOKUP, 8'h00, '0));
    directed.push_back(make_row(ACT_LOOKUP, 8'h80, '0));
    directed.push_back(make_row(ACT_LOOKUP, 8'h7f, '0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_request(directed[i]);

    // Doubling weights build one long chain of deep codes.
    for (int i = 0; i < 16; i++) send_request(make_row(ACT_ADD, SymbolW'(100 + i), FreqW'(1 << i)));
    send_request(make_row(ACT_ADD, 8'd99, 16'd1));
    send_request(make_row(ACT_BUILD, 8'd0, '0));
    for (int i = 0; i < 17; i++) send_request(make_row(ACT_LOOKUP, SymbolW'(99 + i), '0));

    // Random phases: a few adds, a build, then lookups mostly of known symbols.
    sent = 0;
    while (sent < RandomItems) begin
      if (!held && sent > 300) begin
        hold_results = 1'b1;
        held = 1'b1;
      end
      adds = $urandom_range(0, 5);
      for (int i = 0; i < adds; i++) begin
        r = make_row(ACT_ADD, SymbolW'($urandom), random_frequency());
        used_symbols.push_back(r.symbol);
        send_request(r);
      end
      send_request(make_row(ACT_BUILD, SymbolW'($urandom), FreqW'($urandom)));
      lookups = $urandom_range(8, 20);
      for (int i = 0; i < lookups; i++) begin
        if ($urandom_range(0, 9) == 0)
          r = make_row(ACT_UNUSED, SymbolW'($urandom), FreqW'($urandom));
        else if (used_symbols.size() > 0 && $urandom_range(0, 3) != 0)
          r = make_row(ACT_LOOKUP, used_symbols[$urandom_range(0, used_symbols.size() - 1)],
                       FreqW'($urandom));
        else
          r = make_row(ACT_LOOKUP, SymbolW'($urandom), FreqW'($urandom));
        send_request(r);
      end
      sent += adds + 1 + lookups;
    end

    // Fill the leaf store, then try two adds past its capacity and build once more.
    adds = LeafCap + 2 - leaves_loaded;
    for (int i = 0; i < adds; i++)
      send_request(make_row(ACT_ADD, SymbolW'($urandom), random_frequency()));
    send_request(make_row(ACT_BUILD, 8'd0, '0));
    for (int i = 0; i < 24; i++) send_request(make_row(ACT_LOOKUP, SymbolW'($urandom), '0));

    req_if.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 50) begin
      @(posedge clk);
      drain++;
    end
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/htb_pkg.sv
hw/rtl/htb_if.sv
hw/rtl/huffman_code_table_builder.sv
dv/huffman_code_table_builder_test.sv
